/* src/overwriting_event_ring_defines.svh */
// Assertion macros shared by the event ring checker.
`ifndef OVERWRITING_EVENT_RING_DEFINES_SVH
`define OVERWRITING_EVENT_RING_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/oer_pkg.sv */
// Types and constants of the overwriting event ring.
`default_nettype none

package oer_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int PASS_BITS_DEF = 32;

    localparam int CFG_W   = 9;
    localparam int KIND_W  = 5;
    localparam int FAIL_W  = 4;
    localparam int PLD_W   = 64;
    localparam int ENTRY_W = KIND_W + FAIL_W + PLD_W;

    localparam logic [CFG_W-1:0] QSIZE_RESET = 9'd256;

    localparam logic FUNC_POST = 1'b0;
    localparam logic FUNC_GET  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    typedef struct packed {
        logic              func;
        logic [KIND_W-1:0] event_kind;
        logic [FAIL_W-1:0] fail_code;
        logic [PLD_W-1:0]  event_payload;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [KIND_W-1:0] kind_out;
        logic [FAIL_W-1:0] fail_out;
        logic [PLD_W-1:0]  payload_out;
    } out_item_t;

endpackage

`default_nettype wire

/* src/oer_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/overwriting_event_ring.sv */
// Top level of the overwriting event ring.
`default_nettype none

// Overwriting event ring. A post (func 0) stores kind, failure code and
// payload at the producer slot and never blocks; once the producer laps the
// consumer, unread items are overwritten. A get (func 1) returns one result:
// empty (all fields zero), the next item with ok status, or, after a lap,
// the oldest surviving item with dropped status, the consumer having jumped
// straight to it. The block takes one item per cycle while input stall is low.
// A get's result passes through the registered read of the entry RAM and
// then the output register before it shows on the output. Pointer and pass
// updates are done in the accept cycle, so back-to-back posts and gets see
// each other in order. Input stall rises only when both the read stage and
// the output register hold results and the output is stalled. A write of
// queue_size (1..256, 0 acts as 1, above DEPTH acts as DEPTH) resets both
// slots and passes; stored entries stay. The config port is ready only when
// no result is in flight and no input item is offered. No clearing pass runs
// after reset.
module overwriting_event_ring
    import oer_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int PASS_BITS = PASS_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item input
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_item,
    // result output
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_item,
    // queue_size write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(DEPTH);
    // compare width: fits the size register and DEPTH itself
    localparam int CMP_W  = (SLOT_W + 1 > CFG_W) ? SLOT_W + 1 : CFG_W;

    localparam logic [CMP_W-1:0]     CMP_ONE   = CMP_W'(1);
    localparam logic [CMP_W-1:0]     CMP_DEPTH = CMP_W'(DEPTH);
    localparam logic [PASS_BITS-1:0] PASS_ONE  = PASS_BITS'(1);

    // pointer state
    logic [CFG_W-1:0]     qsize_reg;
    logic [SLOT_W-1:0]    wslot_reg,  wslot_next;
    logic [SLOT_W-1:0]    rslot_reg,  rslot_next;
    logic [PASS_BITS-1:0] wpass_reg,  wpass_next;
    logic [PASS_BITS-1:0] rpass_reg,  rpass_next;

    // read stage and output register
    logic                 s1_vld_reg;
    status_t              s1_status_reg;
    logic                 out_vld_reg;
    out_item_t            out_item_reg;

    logic                 cfg_acc;
    logic                 in_acc;
    logic                 do_post;
    logic                 do_get;
    logic                 is_empty;
    logic                 lapped;
    logic                 s1_move;
    logic [CMP_W-1:0]     size_use;
    logic [CMP_W-1:0]     cfg_ext;
    logic [PASS_BITS-1:0] pass_diff;
    logic [SLOT_W-1:0]    rd_slot;
    logic [PASS_BITS-1:0] rd_pass;
    logic [CMP_W-1:0]     w_inc;
    logic [CMP_W-1:0]     r_inc;
    logic                 w_wrap;
    logic                 r_wrap;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    // handshakes; a queue_size write never shares a cycle with an input item
    assign cfg_ready = !s1_vld_reg && !out_vld_reg && !in_valid;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_stall  = s1_vld_reg && out_vld_reg && out_stall;
    assign in_acc    = in_valid && !in_stall;
    assign do_post   = in_acc && (in_item.func == FUNC_POST);
    assign do_get    = in_acc && (in_item.func == FUNC_GET);
    assign s1_move   = s1_vld_reg && (!out_vld_reg || !out_stall);

    // size in use, clamped to 1..DEPTH
    assign cfg_ext = CMP_W'(qsize_reg);

    always_comb
    begin
        if (qsize_reg == '0)
        begin
            size_use = CMP_ONE;
        end
        else if (cfg_ext > CMP_DEPTH)
        begin
            size_use = CMP_DEPTH;
        end
        else
        begin
            size_use = cfg_ext;
        end
    end

    // empty and lap detection
    assign is_empty  = (wslot_reg == rslot_reg) && (wpass_reg == rpass_reg);
    assign pass_diff = wpass_reg - rpass_reg;
    assign lapped    = (pass_diff > PASS_ONE) ||
                       ((pass_diff == PASS_ONE) && (wslot_reg > rslot_reg));

    // lapped consumer restarts at the producer slot, one pass back
    assign rd_slot = lapped ? wslot_reg : rslot_reg;
    assign rd_pass = lapped ? (wpass_reg - PASS_ONE) : rpass_reg;

    // slot advance with wrap
    assign w_inc  = CMP_W'(wslot_reg) + CMP_ONE;
    assign r_inc  = CMP_W'(rd_slot) + CMP_ONE;
    assign w_wrap = (w_inc >= size_use);
    assign r_wrap = (r_inc >= size_use);

    always_comb
    begin
        wslot_next = wslot_reg;
        wpass_next = wpass_reg;
        rslot_next = rslot_reg;
        rpass_next = rpass_reg;
        if (cfg_acc)
        begin
            wslot_next = '0;
            wpass_next = '0;
            rslot_next = '0;
            rpass_next = '0;
        end
        else if (do_post)
        begin
            wslot_next = w_wrap ? '0 : w_inc[SLOT_W-1:0];
            wpass_next = w_wrap ? (wpass_reg + PASS_ONE) : wpass_reg;
        end
        else if (do_get && !is_empty)
        begin
            rslot_next = r_wrap ? '0 : r_inc[SLOT_W-1:0];
            rpass_next = r_wrap ? (rd_pass + PASS_ONE) : rd_pass;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg <= QSIZE_RESET;
            wslot_reg <= '0;
            rslot_reg <= '0;
            wpass_reg <= '0;
            rpass_reg <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                qsize_reg <= cfg_data;
            end
            wslot_reg <= wslot_next;
            rslot_reg <= rslot_next;
            wpass_reg <= wpass_next;
            rpass_reg <= rpass_next;
        end
    end

    // entry store: tag (kind, failure code) above payload
    assign ram_wdata = {in_item.event_kind, in_item.fail_code, in_item.event_payload};

    oer_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_post),
        .wr_addr (wslot_reg),
        .wr_data (ram_wdata),
        .rd_en   (do_get && !is_empty),
        .rd_addr (rd_slot),
        .rd_data (ram_rdata)
    );

    // read stage: status waits beside the RAM read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (do_get)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_get)
        begin
            if (is_empty)
            begin
                s1_status_reg <= ST_EMPTY;
            end
            else if (lapped)
            begin
                s1_status_reg <= ST_DROPPED;
            end
            else
            begin
                s1_status_reg <= ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_item_reg.status <= s1_status_reg;
            if (s1_status_reg == ST_EMPTY)
            begin
                out_item_reg.kind_out    <= '0;
                out_item_reg.fail_out    <= '0;
                out_item_reg.payload_out <= '0;
            end
            else
            begin
                out_item_reg.kind_out    <= ram_rdata[ENTRY_W-1 -: KIND_W];
                out_item_reg.fail_out    <= ram_rdata[PLD_W +: FAIL_W];
                out_item_reg.payload_out <= ram_rdata[PLD_W-1:0];
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

/* src/oer_checker.sv */
// Port-level checks of the overwriting event ring, bound to the top level.
`default_nettype none

`include "overwriting_event_ring_defines.svh"

module oer_checker
    import oer_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire in_item_t         in_item,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire out_item_t        out_item,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [CFG_W-1:0] cfg_data
);

    logic unused_ok;

    assign unused_ok = ^{in_valid, in_item, cfg_data};

    // stalled result holds
    `OER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

    // empty result carries zero fields
    `OER_ASSERT_NOW(a_empty_zero, out_valid && (out_item.status == ST_EMPTY), (out_item.kind_out == '0) && (out_item.fail_out == '0) && (out_item.payload_out == '0), "empty result with nonzero fields")

    // input backs up only behind a stalled, full output
    `OER_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // queue_size write only with no result pending
    `OER_ASSERT_NOW(a_cfg_idle, cfg_valid && cfg_ready, !out_valid, "config taken with result pending")

endmodule

bind overwriting_event_ring oer_checker u_oer_checker (.*);

`default_nettype wire

/* tb/overwriting_event_ring_test.sv */
// Self-checking testbench of the overwriting event ring: directed rows, then random phases.
`default_nettype none

// The run starts with a short directed table: gets on an empty ring, posts with
// all-zero and all-one fields, a two-entry ring the producer laps, and queue
// sizes that fall out of range at either end. Random phases follow. Each phase
// writes a new queue_size and then sends a post/get mix tuned to that size.
// Some mixes let the producer lap the consumer; others keep the ring
// near empty. A model of the ring in this file predicts every get result,
// and a checker matches the results in order as they leave the block.
module overwriting_event_ring_test;
    import oer_pkg::*;

    localparam int SETTLE_CYCLES = 4;     // results leave through the RAM read and output registers
    localparam int TAIL_CYCLES   = 8;
    localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake at all
    localparam int REPORT_LIMIT  = 10;
    localparam int NUM_PHASES    = 10;

    // Random phases: queue size, item count, share of posts, idle gaps on input.
    // 0 and 511 are out of range (act as 1 and 256); big post shares force laps.
    localparam logic [CFG_W-1:0] PHASE_SIZE [NUM_PHASES] =
        '{9'd256, 9'd1, 9'd0, 9'd2, 9'd3, 9'd7, 9'd16, 9'd100, 9'd511, 9'd300};
    localparam int PHASE_ITEMS    [NUM_PHASES] = '{450, 120, 100, 150, 150, 200, 200, 200, 130, 100};
    localparam int PHASE_POST_PCT [NUM_PHASES] = '{90, 50, 60, 60, 40, 70, 50, 85, 50, 30};
    localparam bit PHASE_GAPPY    [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
                                                   1'b0, 1'b1, 1'b1};

    typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

    // One row of the directed table. A typed row carries its result as written.
    typedef struct {
        row_kind_t        kind;
        in_item_t         item;
        bit               typed;
        out_item_t        want;
        logic [CFG_W-1:0] size;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Ring model: size register, producer/consumer slots and lap counts, entries.
    logic [CFG_W-1:0]         qsize_now;
    int unsigned              prod_slot;
    int unsigned              cons_slot;
    logic [PASS_BITS_DEF-1:0] prod_lap;
    logic [PASS_BITS_DEF-1:0] cons_lap;
    logic [KIND_W-1:0]        ev_kind    [DEPTH_DEF];
    logic [FAIL_W-1:0]        ev_fail    [DEPTH_DEF];
    logic [PLD_W-1:0]         ev_payload [DEPTH_DEF];

    out_item_t   pending_events [$];   // get results still owed by the block
    stim_row_t   dir_rows [$];
    bit          row_typed;            // row now on the input carries a typed result
    out_item_t   row_want;
    int unsigned fault_count;
    int unsigned idle_cycles;

    overwriting_event_ring i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    // Out-of-range sizes clamp: 0 acts as 1, anything above the depth as the depth.
    function automatic int unsigned slots_in_use();
        int unsigned n;
        n = qsize_now;
        if (n == 0)
            n = 1;
        if (n > DEPTH_DEF)
            n = DEPTH_DEF;
        return n;
    endfunction

    function automatic void clear_ring_pointers();
        prod_slot = 0;
        cons_slot = 0;
        prod_lap  = '0;
        cons_lap  = '0;
    endfunction

    // Wrap to slot zero and bump the lap count once the next slot leaves the ring.
    function automatic void step_slot(inout int unsigned slot,
                                      inout logic [PASS_BITS_DEF-1:0] lap);
        slot = slot + 1;
        if (slot >= slots_in_use())
        begin
            slot = 0;
            lap  = lap + 1'b1;
        end
    endfunction

    function automatic out_item_t event_result(status_t st, logic [KIND_W-1:0] k,
                                               logic [FAIL_W-1:0] f, logic [PLD_W-1:0] p);
        out_item_t r;
        r.status      = st;
        r.kind_out    = k;
        r.fail_out    = f;
        r.payload_out = p;
        return r;
    endfunction

    // Applies one item to the model; a get always yields exactly one result.
    function automatic void ring_op(input in_item_t it, output bit produced,
                                    output out_item_t res);
        logic [PASS_BITS_DEF-1:0] lap_gap;
        bit                       lapped;
        produced = 1'b0;
        res      = '0;
        if (it.func == FUNC_POST)
        begin
            ev_kind[prod_slot]    = it.event_kind;
            ev_fail[prod_slot]    = it.fail_code;
            ev_payload[prod_slot] = it.event_payload;
            step_slot(prod_slot, prod_lap);
        end
        else
        begin
            produced = 1'b1;
            if (prod_slot == cons_slot && prod_lap == cons_lap)
                res = event_result(ST_EMPTY, '0, '0, '0);
            else
            begin
                // Lapped: more than one pass ahead, or one pass ahead and past us.
                lap_gap = prod_lap - cons_lap;
                lapped  = (lap_gap > 1) || (lap_gap == 1 && prod_slot > cons_slot);
                if (lapped)
                begin
                    // Oldest survivor: producer slot, one pass behind the producer.
                    cons_slot = prod_slot;
                    cons_lap  = prod_lap - 1'b1;
                end
                res = event_result(lapped ? ST_DROPPED : ST_OK, ev_kind[cons_slot],
                                   ev_fail[cons_slot], ev_payload[cons_slot]);
                step_slot(cons_slot, cons_lap);
            end
        end
    endfunction

    // --------------------------------------------------------- stimulus data

    function automatic in_item_t random_item(logic func);
        in_item_t it;
        it.func          = func;
        it.event_kind    = KIND_W'($urandom);
        it.fail_code     = FAIL_W'($urandom);
        it.event_payload = {$urandom, $urandom};
        return it;
    endfunction

    function automatic stim_row_t post_row(logic [KIND_W-1:0] k, logic [FAIL_W-1:0] f,
                                           logic [PLD_W-1:0] p);
        stim_row_t r;
        r.kind                 = ROW_ITEM;
        r.item.func            = FUNC_POST;
        r.item.event_kind      = k;
        r.item.fail_code       = f;
        r.item.event_payload   = p;
        r.typed                = 1'b0;
        r.want                 = '0;
        r.size                 = '0;
        return r;
    endfunction

    function automatic stim_row_t get_row();
        stim_row_t r;
        r      = post_row('0, '0, '0);
        r.item = random_item(FUNC_GET);   // a get ignores its event fields
        return r;
    endfunction

    function automatic stim_row_t get_expect(status_t st, logic [KIND_W-1:0] k,
                                             logic [FAIL_W-1:0] f, logic [PLD_W-1:0] p);
        stim_row_t r;
        r       = get_row();
        r.typed = 1'b1;
        r.want  = event_result(st, k, f, p);
        return r;
    endfunction

    function automatic stim_row_t size_row(logic [CFG_W-1:0] v);
        stim_row_t r;
        r      = post_row('0, '0, '0);
        r.kind = ROW_SIZE;
        r.size = v;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_span();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // -------------------------------------------------------------- drivers

    // Inputs change on the falling edge; the block samples them on the rising one.
    task automatic drive_item(input in_item_t it, input bit typed, input out_item_t want);
        @(negedge clk);
        in_valid  = 1'b1;
        in_item   = it;
        row_typed = typed;
        row_want  = want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic rest_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            in_item  = random_item(1'($urandom));
        end
    endtask

    // Holds the input until every owed result is out; posts yield no result,
    // so a few more cycles let the last of them settle.
    task automatic wait_drained();
        rest_input(1);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_queue_size(input logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data  = CFG_W'($urandom);
    endtask

    // Output stall: runs of stall and of free flow, some free runs long.
    initial
    begin : sink_pacing
        int run_left;
        bit hold;
        run_left  = 0;
        hold      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    hold     = 1'b1;
                    run_left = idle_span();
                end
                else
                begin
                    hold     = 1'b0;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(1, 20);
                end
            end
            out_stall = hold;
            run_left  = run_left - 1;
        end
    end

    // -------------------------------------------------------------- checker

    task automatic note_fault(input string what, input out_item_t got, input out_item_t want);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%s: got status %0d kind %0d fail %0d payload %h",
                     what, got.status, got.kind_out, got.fail_out, got.payload_out);
            $display("    expected status %0d kind %0d fail %0d payload %h",
                     want.status, want.kind_out, want.fail_out, want.payload_out);
        end
    endtask

    // All handshakes are seen here on the rising edge: results out first, then
    // a queue_size write, then an input item through the model.
    always @(posedge clk)
    begin : monitor
        bit        produced;
        bit        moved;
        out_item_t predicted;
        out_item_t oldest;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (pending_events.size() == 0)
                    note_fault("unexpected result", out_item, '0);
                else
                begin
                    oldest = pending_events.pop_front();
                    if (out_item.status !== oldest.status ||
                        out_item.kind_out !== oldest.kind_out ||
                        out_item.fail_out !== oldest.fail_out ||
                        out_item.payload_out !== oldest.payload_out)
                        note_fault("result mismatch", out_item, oldest);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                moved     = 1'b1;
                qsize_now = cfg_data;
                clear_ring_pointers();   // entries keep their contents
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                ring_op(in_item, produced, predicted);
                if (produced)
                    pending_events.push_back(row_typed ? row_want : predicted);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("overwriting_event_ring_test: errors");
        $finish;
    end

    // ------------------------------------------------------------- sequence

    initial
    begin : stimulus
        qsize_now   = QSIZE_RESET;
        clear_ring_pointers();
        fault_count = 0;
        idle_cycles = 0;
        row_typed   = 1'b0;
        row_want    = '0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;

        // Directed table. Typed rows: results that follow from reset and plain order.
        dir_rows.push_back(get_expect(ST_EMPTY, '0, '0, '0));
        dir_rows.push_back(post_row('1, '1, '1));
        dir_rows.push_back(post_row('0, '0, '0));
        dir_rows.push_back(post_row(5'd21, 4'd10, 64'ha5a5_5a5a_0f0f_f0f0));
        dir_rows.push_back(get_expect(ST_OK, '1, '1, '1));
        dir_rows.push_back(get_expect(ST_OK, '0, '0, '0));
        dir_rows.push_back(get_expect(ST_OK, 5'd21, 4'd10, 64'ha5a5_5a5a_0f0f_f0f0));
        dir_rows.push_back(get_expect(ST_EMPTY, '0, '0, '0));
        // two-entry ring: three posts lap the consumer
        dir_rows.push_back(size_row(9'd2));
        dir_rows.push_back(post_row(5'd1, 4'd1, 64'd1));
        dir_rows.push_back(post_row(5'd2, 4'd2, 64'd2));
        dir_rows.push_back(post_row(5'd3, 4'd3, 64'd3));
        dir_rows.push_back(get_row());
        dir_rows.push_back(get_row());
        dir_rows.push_back(get_row());
        // size zero acts as one entry: every post wraps
        dir_rows.push_back(size_row(9'd0));
        dir_rows.push_back(post_row(5'd4, 4'd4, 64'h8000_0000_0000_0000));
        dir_rows.push_back(get_row());
        dir_rows.push_back(post_row(5'd5, 4'd5, 64'd5));
        dir_rows.push_back(post_row(5'd6, 4'd6, 64'd6));
        dir_rows.push_back(get_row());
        dir_rows.push_back(get_row());
        // oversize acts as full depth
        dir_rows.push_back(size_row(9'd511));
        dir_rows.push_back(post_row(5'd16, 4'd8, 64'h0000_0001_0000_0000));
        dir_rows.push_back(get_row());

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SIZE)
                set_queue_size(dir_rows[i].size);
            else
                drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_queue_size(PHASE_SIZE[ph]);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                // halfway through, the sender waits for every owed result
                if (n == PHASE_ITEMS[ph] / 2)
                    wait_drained();
                if (PHASE_GAPPY[ph] && $urandom_range(0, 99) < 40)
                    rest_input(idle_span());
                drive_item(random_item(($urandom_range(0, 99) < PHASE_POST_PCT[ph])
                                       ? FUNC_POST : FUNC_GET), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            fault_count += pending_events.size();
            $display("%0d expected results never arrived", pending_events.size());
        end
        if (fault_count == 0)
            $display("overwriting_event_ring_test: clean");
        else
            $display("overwriting_event_ring_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
